[design/bgy_pkg.sv]
// Package for the BGR to YUV 4:2:0 converter: frame register codes, coefficients,
// queue sizing and the item that passes from the front end to the back end.
// No dependencies.
`default_nettype none

package bgy_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	// configuration port
	localparam int CFG_DW = 13;
	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1
	} cfg_idx_t;

	localparam logic [CFG_DW-1:0] FRAME_WIDTH_RST  = 13'd1920;
	localparam logic [CFG_DW-1:0] FRAME_HEIGHT_RST = 13'd1080;

	// queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// BT.601 limited range coefficients (magnitudes)
	localparam logic [7:0] Y_COEF_R  = 8'd66;
	localparam logic [7:0] Y_COEF_G  = 8'd129;
	localparam logic [7:0] Y_COEF_B  = 8'd25;
	localparam logic [7:0] CB_COEF_R = 8'd38;
	localparam logic [7:0] CB_COEF_G = 8'd74;
	localparam logic [7:0] CB_COEF_B = 8'd112;
	localparam logic [7:0] CR_COEF_R = 8'd112;
	localparam logic [7:0] CR_COEF_G = 8'd94;
	localparam logic [7:0] CR_COEF_B = 8'd18;

	localparam logic [7:0] LUMA_MIN   = 8'd16;
	localparam logic [7:0] LUMA_MAX   = 8'd235;
	localparam logic [7:0] CHROMA_MIN = 8'd16;
	localparam logic [7:0] CHROMA_MAX = 8'd240;
	localparam logic [7:0] ROUND_HALF = 8'd128;

	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [9:0]  sum_b;
		logic [9:0]  sum_g;
		logic [9:0]  sum_r;
		logic [11:0] col;
		logic [11:0] row;
		logic        closes;
		logic        frame_end;
	} bgy_item_t;

	// frame dimension limited to 1..maxv, returned minus one
	function automatic int lim_m1(input int v, input int maxv);
		if (v < 1)
			return 0;
		if (v > maxv)
			return maxv - 1;
		return v - 1;
	endfunction

endpackage

`default_nettype wire

[design/bgy_pix_if.sv]
// Pixel input channel: valid/ready handshake with blue, green and red components.
// No dependencies.
`default_nettype none

interface bgy_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	modport source (output valid, blue, green, red, input ready);
	modport sink   (input valid, blue, green, red, output ready);
endinterface

`default_nettype wire

[design/bgy_res_if.sv]
// Result channel: valid/ready handshake with luma, chroma and position fields.
// No dependencies.
`default_nettype none

interface bgy_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  luma;
	logic [11:0] luma_col;
	logic [11:0] luma_row;
	logic        chroma_valid;
	logic [7:0]  cb;
	logic [7:0]  cr;
	logic [10:0] chroma_col;
	logic [10:0] chroma_row;
	logic        frame_end;

	modport source (output valid, luma, luma_col, luma_row, chroma_valid, cb, cr,
		chroma_col, chroma_row, frame_end, input ready);
	modport sink   (input valid, luma, luma_col, luma_row, chroma_valid, cb, cr,
		chroma_col, chroma_row, frame_end, output ready);
endinterface

`default_nettype wire

[design/bgy_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bgy_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/bgy_front.sv]
// Front end: frame registers, raster counters, line store access and 2x2 box sums.
// Uses bgy_pkg, bgy_pix_if and bgy_ram.
`default_nettype none

module bgy_front #(
	parameter int MAX_WIDTH  = bgy_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bgy_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bgy_pix_if.sink                           pix,
	input  wire logic                         cfg_we,
	input  wire logic [bgy_pkg::CFG_IW-1:0]   cfg_idx,
	input  wire logic [bgy_pkg::CFG_DW-1:0]   cfg_data,
	input  wire logic [bgy_pkg::Q_CNT_W-1:0]  q_count,
	output logic                              push,
	output bgy_pkg::bgy_item_t                push_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q, w_last_q;
	logic [RW-1:0] row_q, h_last_q;
	logic          fire, last_col, last_row, closes;
	logic [23:0]   px, rd;

	logic          s1_valid;
	logic [23:0]   s1_px;
	logic [11:0]   s1_col, s1_row;
	logic          s1_closes, s1_fend;
	logic [23:0]   held_px_q, held_up_q;
	logic [23:0]   cur0, left0, cur1, left1;

	function automatic logic [9:0] add4(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		return 10'(a) + 10'(b) + 10'(c) + 10'(d);
	endfunction

	assign pix.ready = (int'(q_count) + int'(s1_valid)) < bgy_pkg::QUEUE_DEPTH;
	assign fire      = pix.valid && pix.ready;
	assign px        = {pix.red, pix.green, pix.blue};
	assign last_col  = col_q >= w_last_q;
	assign last_row  = row_q >= h_last_q;
	assign closes    = (col_q[0] || last_col) && (row_q[0] || last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			w_last_q <= CW'(bgy_pkg::lim_m1(int'(bgy_pkg::FRAME_WIDTH_RST), MAX_WIDTH));
			h_last_q <= RW'(bgy_pkg::lim_m1(int'(bgy_pkg::FRAME_HEIGHT_RST), MAX_HEIGHT));
		end else if (cfg_we) begin
			case (cfg_idx)
				bgy_pkg::CFG_FRAME_WIDTH: begin
					w_last_q <= CW'(bgy_pkg::lim_m1(int'(cfg_data), MAX_WIDTH));
					col_q    <= '0;
					row_q    <= '0;
				end
				bgy_pkg::CFG_FRAME_HEIGHT: begin
					h_last_q <= RW'(bgy_pkg::lim_m1(int'(cfg_data), MAX_HEIGHT));
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// even rows are written, odd rows read back the pixel above
	bgy_ram #(
		.WIDTH (24),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (fire && !row_q[0]),
		.waddr (col_q),
		.wdata (px),
		.re    (fire && row_q[0]),
		.raddr (col_q),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else
			s1_valid <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s1_px     <= px;
			s1_col    <= 12'(col_q);
			s1_row    <= 12'(row_q);
			s1_closes <= closes;
			s1_fend   <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_px_q <= '0;
		else if (s1_valid)
			held_px_q <= s1_px;
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_row[0])
			held_up_q <= rd;
	end

	// lone last column or row replicates the present pixels
	always_comb begin
		cur1  = s1_px;
		left1 = s1_col[0] ? held_px_q : s1_px;
		if (s1_row[0]) begin
			cur0  = rd;
			left0 = s1_col[0] ? held_up_q : rd;
		end else begin
			cur0  = cur1;
			left0 = left1;
		end
	end

	assign push                = s1_valid;
	assign push_item.blue      = s1_px[7:0];
	assign push_item.green     = s1_px[15:8];
	assign push_item.red       = s1_px[23:16];
	assign push_item.sum_b     = add4(cur0[7:0], left0[7:0], cur1[7:0], left1[7:0]);
	assign push_item.sum_g     = add4(cur0[15:8], left0[15:8], cur1[15:8], left1[15:8]);
	assign push_item.sum_r     = add4(cur0[23:16], left0[23:16], cur1[23:16], left1[23:16]);
	assign push_item.col       = s1_col;
	assign push_item.row       = s1_row;
	assign push_item.closes    = s1_closes;
	assign push_item.frame_end = s1_fend;

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> int'(q_count) < bgy_pkg::QUEUE_DEPTH)
		else $error("front pushed into a full queue");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last_q)
		else $error("column count beyond frame width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last_q)
		else $error("row count beyond frame height");

endmodule

`default_nettype wire

[design/bgy_queue.sv]
// Short item queue between front and back ends, register based.
// Uses bgy_pkg.
`default_nettype none

module bgy_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire bgy_pkg::bgy_item_t           push_item,
	input  wire logic                         pop,
	output bgy_pkg::bgy_item_t                head,
	output logic [bgy_pkg::Q_CNT_W-1:0]       count,
	output logic                              not_empty
);

	bgy_pkg::bgy_item_t                 mem_q [bgy_pkg::QUEUE_DEPTH];
	logic [bgy_pkg::Q_PTR_W-1:0]        wptr_q, rptr_q;
	logic [bgy_pkg::Q_CNT_W-1:0]        count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head      = mem_q[rptr_q];
	assign count     = count_q;
	assign not_empty = count_q != '0;

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (int'(count_q) < bgy_pkg::QUEUE_DEPTH || pop))
		else $error("queue pushed while full");

endmodule

`default_nettype wire

[design/bgy_back.sv]
// Back end: coefficient products, luma and chroma sums, clamping and output register.
// Uses bgy_pkg and bgy_res_if.
`default_nettype none

module bgy_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_not_empty,
	input  wire bgy_pkg::bgy_item_t head,
	output logic                    pop,
	bgy_res_if.source               res
);

	logic        adv;
	logic [7:0]  avg_b, avg_g, avg_r;

	logic        b1_valid;
	logic [15:0] b1_yr, b1_yg, b1_yb;
	logic [15:0] b1_cbr, b1_cbg, b1_cbb;
	logic [15:0] b1_crr, b1_crg, b1_crb;
	logic [11:0] b1_col, b1_row;
	logic        b1_closes, b1_fend;

	logic [16:0]        y_sum;
	logic [8:0]         y_v;
	logic [7:0]         y_c, cb_c, cr_c;
	logic signed [17:0] cb_s, cr_s, cb_f, cr_f;

	logic        out_valid_q;
	logic [7:0]  luma_q, cb_q, cr_q;
	logic [11:0] col_q, row_q;
	logic [10:0] ccol_q, crow_q;
	logic        cval_q, fend_q;

	assign adv   = !out_valid_q || res.ready;
	assign pop   = adv && q_not_empty;
	assign avg_b = 8'((head.sum_b + 10'd2) >> 2);
	assign avg_g = 8'((head.sum_g + 10'd2) >> 2);
	assign avg_r = 8'((head.sum_r + 10'd2) >> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			b1_valid <= 1'b0;
		else if (adv)
			b1_valid <= q_not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			b1_yr     <= 16'(head.red) * 16'(bgy_pkg::Y_COEF_R);
			b1_yg     <= 16'(head.green) * 16'(bgy_pkg::Y_COEF_G);
			b1_yb     <= 16'(head.blue) * 16'(bgy_pkg::Y_COEF_B);
			b1_cbr    <= 16'(avg_r) * 16'(bgy_pkg::CB_COEF_R);
			b1_cbg    <= 16'(avg_g) * 16'(bgy_pkg::CB_COEF_G);
			b1_cbb    <= 16'(avg_b) * 16'(bgy_pkg::CB_COEF_B);
			b1_crr    <= 16'(avg_r) * 16'(bgy_pkg::CR_COEF_R);
			b1_crg    <= 16'(avg_g) * 16'(bgy_pkg::CR_COEF_G);
			b1_crb    <= 16'(avg_b) * 16'(bgy_pkg::CR_COEF_B);
			b1_col    <= head.col;
			b1_row    <= head.row;
			b1_closes <= head.closes;
			b1_fend   <= head.frame_end;
		end
	end

	// arithmetic shifts floor the negative chroma sums
	always_comb begin
		y_sum = 17'(b1_yr) + 17'(b1_yg) + 17'(b1_yb) + 17'(bgy_pkg::ROUND_HALF);
		y_v   = y_sum[16:8] + 9'(bgy_pkg::LUMA_MIN);
		y_c   = (y_v > 9'(bgy_pkg::LUMA_MAX)) ? bgy_pkg::LUMA_MAX : y_v[7:0];

		cb_s = $signed({2'b00, b1_cbb}) - $signed({2'b00, b1_cbr})
			- $signed({2'b00, b1_cbg}) + $signed(18'(bgy_pkg::ROUND_HALF));
		cr_s = $signed({2'b00, b1_crr}) - $signed({2'b00, b1_crg})
			- $signed({2'b00, b1_crb}) + $signed(18'(bgy_pkg::ROUND_HALF));
		cb_f = (cb_s >>> 8) + $signed(18'(bgy_pkg::ROUND_HALF));
		cr_f = (cr_s >>> 8) + $signed(18'(bgy_pkg::ROUND_HALF));

		if (cb_f < $signed(18'(bgy_pkg::CHROMA_MIN)))
			cb_c = bgy_pkg::CHROMA_MIN;
		else if (cb_f > $signed(18'(bgy_pkg::CHROMA_MAX)))
			cb_c = bgy_pkg::CHROMA_MAX;
		else
			cb_c = cb_f[7:0];

		if (cr_f < $signed(18'(bgy_pkg::CHROMA_MIN)))
			cr_c = bgy_pkg::CHROMA_MIN;
		else if (cr_f > $signed(18'(bgy_pkg::CHROMA_MAX)))
			cr_c = bgy_pkg::CHROMA_MAX;
		else
			cr_c = cr_f[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= b1_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && b1_valid) begin
			luma_q <= y_c;
			col_q  <= b1_col;
			row_q  <= b1_row;
			cval_q <= b1_closes;
			cb_q   <= b1_closes ? cb_c : 8'd0;
			cr_q   <= b1_closes ? cr_c : 8'd0;
			ccol_q <= b1_closes ? b1_col[11:1] : 11'd0;
			crow_q <= b1_closes ? b1_row[11:1] : 11'd0;
			fend_q <= b1_fend;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.luma         = luma_q;
	assign res.luma_col     = col_q;
	assign res.luma_row     = row_q;
	assign res.chroma_valid = cval_q;
	assign res.cb           = cb_q;
	assign res.cr           = cr_q;
	assign res.chroma_col   = ccol_q;
	assign res.chroma_row   = crow_q;
	assign res.frame_end    = fend_q;

	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !cval_q |-> cb_q == 8'd0 && cr_q == 8'd0 && ccol_q == 11'd0
			&& crow_q == 11'd0)
		else $error("chroma fields set on item without a closed block");

endmodule

`default_nettype wire

[design/bgra_to_yuv420_bt601.sv]
// Top level of the BGR to YUV 4:2:0 BT.601 converter.
// Uses bgy_pkg, bgy_pix_if, bgy_res_if, bgy_front, bgy_queue and bgy_back.
//
// Pixels enter on pix in raster order (blue, green, red) with a valid/ready
// handshake; every accepted pixel gives exactly one item on res, carrying its
// luma and position. On the pixel that completes a 2x2 block (odd column or
// last column, on an odd row or the last row) the item also carries Cb/Cr of
// the rounded block average, and chroma_valid is high.
// Frame size is set through cfg_we/cfg_idx/cfg_data; a write to either
// register restarts the frame at row 0, column 0. Write only while idle.
// Throughput: one pixel per clock while the queue has room. Each pixel passes
// the front register, queue, product stage and output before res.valid rises.
// The line store is a MAX_WIDTH x 24 RAM, written on even rows and read on odd
// rows, one access per pixel.
// Reset: counters to zero, frame size 1920 x 1080, all pipeline stages empty.
// When res.ready is low the output register holds; the queue between the
// front and back ends absorbs the items in flight, and pix.ready drops once
// the queue count plus the item in the front register fills the queue.
`default_nettype none

module bgra_to_yuv420_bt601 #(
	parameter int MAX_WIDTH  = bgy_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bgy_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bgy_pix_if.sink                         pix,
	bgy_res_if.source                       res,
	input  wire logic                       cfg_we,
	input  wire logic [bgy_pkg::CFG_IW-1:0] cfg_idx,
	input  wire logic [bgy_pkg::CFG_DW-1:0] cfg_data
);

	logic                         push, pop, q_not_empty;
	bgy_pkg::bgy_item_t           push_item, head;
	logic [bgy_pkg::Q_CNT_W-1:0]  q_count;

	bgy_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (push),
		.push_item (push_item)
	);

	bgy_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.count     (q_count),
		.not_empty (q_not_empty)
	);

	bgy_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.res         (res)
	);

endmodule

`default_nettype wire
